### rtl/core/bswh_pkg.sv
package bswh_pkg;

  localparam int WL_BITS = 9;
  localparam logic [WL_BITS-1:0] WINDOW_LENGTH_RESET = 9'd20;

  localparam int SEEN_BITS = 16;
  localparam logic [SEEN_BITS-1:0] SEEN_MAX = 16'hFFFF;

  // wide enough to hold any store depth and any window length
  localparam int SPAN_BITS = 17;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

### rtl/core/bswh_ram.sv
module bswh_ram #(
  parameter int DEPTH     = 256,
  parameter int DATA_BITS = 32
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [DATA_BITS-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [DATA_BITS-1:0]                        rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/bars_since_window_high_unit.sv
// Bars since window high.
// Input channel: sample (signed) and restart, transferred on in_valid & in_ready.
// Output channel: bars_since_high, transferred on out_valid & out_ready; one
// result per input, in order.
// Configuration: cfg_wen writes cfg_wdata into window_length at once; write
// only while the block is idle. Length 0 selects the whole series history.
// Each sample is written into a ring memory; the window maximum is found by
// reading the ring one entry per cycle from newest to oldest across the
// window (len = effective window length, at most WINDOW_DEPTH); with len 1 or
// in whole-history mode the scan is skipped. The ring has a single read port.
// One item is in work at a time; the next transfer is taken once the result
// has moved into the output register, which holds it while the receiver stalls.
// A result waiting in the output register stalls the input only when the
// following result is also ready.
// Reset: window_length returns to 20, series history and counters clear, and
// the first sample after reset starts a new series.
module bars_since_window_high_unit import bswh_pkg::*; #(
  parameter int WINDOW_DEPTH = 256,
  parameter int SAMPLE_BITS  = 32,
  parameter int AGE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [AGE_BITS-1:0]           bars_since_high,
  input  logic                          cfg_wen,
  input  logic [WL_BITS-1:0]            cfg_wdata
);

  localparam int ADDR_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [ADDR_BITS-1:0] LAST_SLOT = ADDR_BITS'(WINDOW_DEPTH - 1);
  localparam logic [AGE_BITS-1:0]  AGE_MAX   = '1;

  state_t state, state_next;

  logic [WL_BITS-1:0]     window_length;
  logic [ADDR_BITS-1:0]   write_slot;
  logic [SEEN_BITS-1:0]   samples_seen;
  logic [SAMPLE_BITS-1:0] high_value;
  logic [AGE_BITS-1:0]    high_age;

  logic [SAMPLE_BITS-1:0] best;
  logic [WL_BITS-1:0]     best_age;
  logic [WL_BITS-1:0]     remaining;
  logic [WL_BITS-1:0]     issue_age;
  logic [WL_BITS-1:0]     pend_age;
  logic                   rd_pend;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   whole_mode;

  logic                   accept;
  logic                   scan_issue;
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] key;
  logic [SEEN_BITS-1:0]   seen_base;
  logic [SEEN_BITS-1:0]   seen_next;
  logic                   new_series;
  logic                   high_take;
  logic [AGE_BITS-1:0]    high_age_next;
  logic [SPAN_BITS-1:0]   len_cap;
  logic [SPAN_BITS-1:0]   len_fit;
  logic [WL_BITS-1:0]     scan_len;
  logic                   whole_req;

  assign accept = in_valid & in_ready;
  assign key    = {~sample[SAMPLE_BITS-1], sample[SAMPLE_BITS-2:0]};

  assign seen_base  = restart ? '0 : samples_seen;
  assign new_series = (seen_base == '0);
  assign seen_next  = (seen_base == SEEN_MAX) ? seen_base : seen_base + 1'b1;

  assign high_take     = new_series || (key >= high_value);
  assign high_age_next = high_take ? '0 :
                         (high_age == AGE_MAX) ? high_age : high_age + 1'b1;

  assign whole_req = (window_length == '0);
  assign len_cap   = (SPAN_BITS'(window_length) > SPAN_BITS'(WINDOW_DEPTH)) ?
                     SPAN_BITS'(WINDOW_DEPTH) : SPAN_BITS'(window_length);
  assign len_fit   = (len_cap > SPAN_BITS'(seen_next)) ? SPAN_BITS'(seen_next) : len_cap;
  assign scan_len  = len_fit[WL_BITS-1:0];

  bswh_ram #(
    .DEPTH     (WINDOW_DEPTH),
    .DATA_BITS (SAMPLE_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (write_slot),
    .wr_data (key),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (whole_req || scan_len <= WL_BITS'(1)) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (remaining == '0 && !rd_pend) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    scan_issue = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: in_ready   = 1'b1;
      ST_SCAN: scan_issue = (remaining != '0);
      ST_EMIT: out_load   = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
    end else if (cfg_wen) begin
      window_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      samples_seen <= '0;
      high_value   <= '0;
      high_age     <= '0;
    end else if (accept) begin
      write_slot   <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      samples_seen <= seen_next;
      if (high_take) begin
        high_value <= key;
      end
      high_age     <= high_age_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      remaining <= '0;
    end else if (accept) begin
      rd_pend   <= 1'b0;
      remaining <= whole_req ? '0 : scan_len - 1'b1;
    end else begin
      rd_pend <= scan_issue;
      if (scan_issue) begin
        remaining <= remaining - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      best       <= key;
      best_age   <= '0;
      issue_age  <= WL_BITS'(1);
      whole_mode <= whole_req;
      rd_addr    <= (write_slot == '0) ? LAST_SLOT : write_slot - 1'b1;
    end else begin
      pend_age <= issue_age;
      if (scan_issue) begin
        issue_age <= issue_age + 1'b1;
        rd_addr   <= (rd_addr == '0) ? LAST_SLOT : rd_addr - 1'b1;
      end
      if (rd_pend && rd_data > best) begin
        best     <= rd_data;
        best_age <= pend_age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bars_since_high <= whole_mode ? high_age : AGE_BITS'(best_age);
    end
  end

  a_whole_emit: assert property (@(posedge clk) disable iff (rst)
    accept && whole_req |=> state == ST_EMIT)
    else $error("whole-history item did not go straight to emit");

  a_best_age: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> best_age < issue_age)
    else $error("best age beyond the ages already read");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && remaining == '0 && !rd_pend |=> state == ST_EMIT)
    else $error("scan did not finish after the last read");

  a_new_series: assert property (@(posedge clk) disable iff (rst)
    accept && new_series |=> high_age == '0 && samples_seen == SEEN_BITS'(1))
    else $error("new series did not restart the history");

endmodule
